// ----- src/blr_pkg.sv -----
// ----------------------------------------------------------------------------
// Brush line rasterizer package
// Shared widths, action and register codes, reset values and the brush job
// record handed from the line stepper to the pixel emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package blr_pkg;

   // Default limits for the top-level parameters.
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int MAX_BRUSH_DEF  = 5;

   // Field widths.
   localparam int ACTION_W = 2;
   localparam int SCREEN_W = 12;
   localparam int COORD_W  = 13;
   localparam int DELTA_W  = 14;
   localparam int ERR_W    = 16;
   localparam int DIM_W    = 11;
   localparam int SIZE_W   = 3;
   localparam int COLOR_W  = 32;
   localparam int PIX_W    = 10;
   localparam int ADDR_W   = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Input actions.
   localparam logic [ACTION_W-1:0] ACT_PEN_DOWN = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_MOVE_TO  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_STEP     = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BRUSH_SIZE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PEN_COLOR     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y      = 3'd5;

   // Register reset values.
   localparam logic [DIM_W-1:0]    RST_CANVAS_WIDTH  = 11'd586;
   localparam logic [DIM_W-1:0]    RST_CANVAS_HEIGHT = 11'd256;
   localparam logic [SIZE_W-1:0]   RST_BRUSH_SIZE    = 3'd2;
   localparam logic [COLOR_W-1:0]  RST_PEN_COLOR     = 32'hFF00_0000;
   localparam logic [SCREEN_W-1:0] RST_ORIGIN_X      = 12'd2;
   localparam logic [SCREEN_W-1:0] RST_ORIGIN_Y      = 12'd72;

   // One brush stamp: the line point plus the settings it is drawn with.
   typedef struct packed {
      logic signed [COORD_W-1:0] cur_x;
      logic signed [COORD_W-1:0] cur_y;
      logic [DIM_W-1:0]          width;
      logic [DIM_W-1:0]          height;
      logic [SIZE_W-1:0]         size;
      logic [COLOR_W-1:0]        color;
      logic                      at_end;
   } brush_job_type;

endpackage

// ----- src/blr_req_if.sv -----
// ----------------------------------------------------------------------------
// Brush line rasterizer request channel
// Valid/ready channel carrying one pointer event item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface blr_req_if;
   logic                             valid;
   logic                             ready;
   logic [blr_pkg::ACTION_W-1:0]     action;
   logic [blr_pkg::SCREEN_W-1:0]     pointer_x;
   logic [blr_pkg::SCREEN_W-1:0]     pointer_y;

   modport source (output valid, action, pointer_x, pointer_y, input ready);
   modport sink   (input valid, action, pointer_x, pointer_y, output ready);
endinterface

// ----- src/blr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Brush line rasterizer response channel
// Valid/ready channel carrying one brush pixel item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface blr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [blr_pkg::PIX_W-1:0]     pixel_x;
   logic [blr_pkg::PIX_W-1:0]     pixel_y;
   logic [blr_pkg::ADDR_W-1:0]    pixel_address;
   logic [blr_pkg::COLOR_W-1:0]   pixel_color;
   logic                          write_enable;
   logic                          last_of_step;
   logic                          line_done;

   modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_color,
                   write_enable, last_of_step, line_done, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_address, pixel_color,
                   write_enable, last_of_step, line_done, output ready);
endinterface

// ----- src/blr_brush_emit.sv -----
// ----------------------------------------------------------------------------
// Brush pixel emitter
// Walks the square brush of one stamp in row-major order, one pixel per
// cycle unless stalled, clips it to the canvas and registers the pixel item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blr_brush_emit #(
   parameter int MAX_BRUSH = blr_pkg::MAX_BRUSH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  blr_pkg::brush_job_type job,
   output logic                   job_ready,
   blr_rsp_if.source              rsp_chan
);

   localparam int BW = (MAX_BRUSH > 1) ? $clog2(MAX_BRUSH) : 1;
   localparam int SW = blr_pkg::SIZE_W;
   localparam int CW = blr_pkg::COORD_W;
   localparam int PW = blr_pkg::COORD_W + 1;
   localparam int DW = blr_pkg::DIM_W;

   logic                   busy_ff, busy_in;
   blr_pkg::brush_job_type job_ff, job_in;
   logic [BW-1:0]          bx_ff, bx_in;
   logic [BW-1:0]          by_ff, by_in;

   logic                          out_valid_ff, out_valid_in;
   logic [blr_pkg::PIX_W-1:0]     out_x_ff, out_x_in;
   logic [blr_pkg::PIX_W-1:0]     out_y_ff, out_y_in;
   logic [blr_pkg::ADDR_W-1:0]    out_addr_ff, out_addr_in;
   logic [blr_pkg::COLOR_W-1:0]   out_color_ff, out_color_in;
   logic                          out_we_ff, out_we_in;
   logic                          out_last_ff, out_last_in;
   logic                          out_done_ff, out_done_in;

   logic                 advance;
   logic                 last_col;
   logic                 last_row;
   logic                 pix_last;
   logic signed [PW-1:0] px;
   logic signed [PW-1:0] py;
   logic                 on_canvas;
   logic [2*DW-1:0]      row_offset;
   logic [2*DW-1:0]      addr_sum;

   assign advance  = busy_ff && (!out_valid_ff || rsp_chan.ready);
   assign last_col = (SW'(bx_ff) == job_ff.size - SW'(1));
   assign last_row = (SW'(by_ff) == job_ff.size - SW'(1));
   assign pix_last = last_col && last_row;
   assign job_ready = !busy_ff || (advance && pix_last);

   // Pixel position and clipping against the canvas.
   assign px = $signed({job_ff.cur_x[CW-1], job_ff.cur_x}) + $signed(PW'(bx_ff));
   assign py = $signed({job_ff.cur_y[CW-1], job_ff.cur_y}) + $signed(PW'(by_ff));
   assign on_canvas = !px[PW-1] && (px[CW-1:0] < CW'(job_ff.width))
                   && !py[PW-1] && (py[CW-1:0] < CW'(job_ff.height));

   // Inside the canvas both coordinates are below the width and height.
   assign row_offset = py[DW-1:0] * job_ff.width;
   assign addr_sum   = row_offset + (2*DW)'(px[DW-1:0]);

   always_comb begin
      busy_in = busy_ff;
      job_in  = job_ff;
      bx_in   = bx_ff;
      by_in   = by_ff;
      if (job_valid) begin
         busy_in = 1'b1;
         job_in  = job;
         bx_in   = '0;
         by_in   = '0;
      end else if (advance) begin
         if (pix_last) begin
            busy_in = 1'b0;
         end
         if (last_col) begin
            bx_in = '0;
            by_in = by_ff + BW'(1);
         end else begin
            bx_in = bx_ff + BW'(1);
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_addr_in  = out_addr_ff;
      out_color_in = out_color_ff;
      out_we_in    = out_we_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_x_in     = on_canvas ? px[blr_pkg::PIX_W-1:0] : '0;
         out_y_in     = on_canvas ? py[blr_pkg::PIX_W-1:0] : '0;
         out_addr_in  = on_canvas ? addr_sum[blr_pkg::ADDR_W-1:0] : '0;
         out_color_in = job_ff.color;
         out_we_in    = on_canvas;
         out_last_in  = pix_last;
         out_done_in  = pix_last && job_ff.at_end;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff       <= job_in;
      bx_ff        <= bx_in;
      by_ff        <= by_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_addr_ff  <= out_addr_in;
      out_color_ff <= out_color_in;
      out_we_ff    <= out_we_in;
      out_last_ff  <= out_last_in;
      out_done_ff  <= out_done_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.pixel_x       = out_x_ff;
   assign rsp_chan.pixel_y       = out_y_ff;
   assign rsp_chan.pixel_address = out_addr_ff;
   assign rsp_chan.pixel_color   = out_color_ff;
   assign rsp_chan.write_enable  = out_we_ff;
   assign rsp_chan.last_of_step  = out_last_ff;
   assign rsp_chan.line_done     = out_done_ff;

endmodule

// ----- src/brush_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// Brush line rasterizer
// Turns pointer events into square-brush pixel writes along a line.
// The req channel takes one event item: pen_down stores the previous point,
// move_to starts a line from the previous point to the new one, and step
// stamps the brush at the current line point and advances the line. Screen
// coordinates are made canvas-relative by subtracting the origin registers.
// A step on an active line yields the saturated brush size squared pixel items
// on the rsp channel in row-major brush order; each carries x, y, linear address,
// color, a write enable that is low for pixels off the canvas, a flag on the
// last pixel of the stamp and a flag when that stamp is the line's endpoint.
// An accepted step is held in the emitter's job register, and its pixel
// items then pass the output register. The emitter produces one pixel per
// cycle while the receiver is not stalling, 1 to 25 a step at the default
// limit; the next item is accepted in the cycle that the last pixel enters
// the output register; pen_down, move_to, step items flow gap-free otherwise.
// When the receiver stalls, the output register holds its item and the
// emitter pauses; req stays ready until the emitter has a stamp in flight.
// Reset clears the line and previous-point state, empties the output
// register and restores every configuration register to its default.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brush_line_rasterizer #(
   parameter int MAX_WIDTH  = blr_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = blr_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_BRUSH  = blr_pkg::MAX_BRUSH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   blr_req_if.sink                           req_chan,
   blr_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [blr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [blr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CW = blr_pkg::COORD_W;
   localparam int DLW = blr_pkg::DELTA_W;
   localparam int EW = blr_pkg::ERR_W;
   localparam int DW = blr_pkg::DIM_W;
   localparam int SW = blr_pkg::SIZE_W;

   // Configuration registers.
   logic [DW-1:0]                canvas_width_ff, canvas_width_in;
   logic [DW-1:0]                canvas_height_ff, canvas_height_in;
   logic [SW-1:0]                brush_size_ff, brush_size_in;
   logic [blr_pkg::COLOR_W-1:0]  pen_color_ff, pen_color_in;
   logic [blr_pkg::SCREEN_W-1:0] origin_x_ff, origin_x_in;
   logic [blr_pkg::SCREEN_W-1:0] origin_y_ff, origin_y_in;

   // Line state.
   logic                  prev_valid_ff, prev_valid_in;
   logic signed [CW-1:0]  prev_x_ff, prev_x_in;
   logic signed [CW-1:0]  prev_y_ff, prev_y_in;
   logic                  line_active_ff, line_active_in;
   logic signed [CW-1:0]  cur_x_ff, cur_x_in;
   logic signed [CW-1:0]  cur_y_ff, cur_y_in;
   logic signed [CW-1:0]  end_x_ff, end_x_in;
   logic signed [CW-1:0]  end_y_ff, end_y_in;
   logic signed [DLW-1:0] delta_x_ff, delta_x_in;
   logic signed [DLW-1:0] delta_y_neg_ff, delta_y_neg_in;
   logic [1:0]            step_dirs_ff, step_dirs_in;
   logic signed [EW-1:0]  error_term_ff, error_term_in;

   logic                   req_fire;
   logic                   job_valid;
   logic                   job_ready;
   blr_pkg::brush_job_type job;

   logic signed [CW-1:0]  new_x;
   logic signed [CW-1:0]  new_y;
   logic signed [DLW-1:0] diff_x;
   logic signed [DLW-1:0] diff_y;
   logic signed [DLW-1:0] abs_dx;
   logic signed [DLW-1:0] neg_dy;
   logic signed [EW:0]    e2;
   logic                  step_x;
   logic                  step_y;
   logic                  at_end;
   logic [SW-1:0]         size_sat;
   logic [DW-1:0]         width_sat;
   logic [DW-1:0]         height_sat;

   // ---------------------------------------------------------------------
   // Configuration writes.
   // ---------------------------------------------------------------------
   always_comb begin
      canvas_width_in  = canvas_width_ff;
      canvas_height_in = canvas_height_ff;
      brush_size_in    = brush_size_ff;
      pen_color_in     = pen_color_ff;
      origin_x_in      = origin_x_ff;
      origin_y_in      = origin_y_ff;
      if (csr_we) begin
         case (csr_index)
            blr_pkg::CSR_CANVAS_WIDTH:  canvas_width_in  = csr_wdata[DW-1:0];
            blr_pkg::CSR_CANVAS_HEIGHT: canvas_height_in = csr_wdata[DW-1:0];
            blr_pkg::CSR_BRUSH_SIZE:    brush_size_in    = csr_wdata[SW-1:0];
            blr_pkg::CSR_PEN_COLOR:     pen_color_in     = csr_wdata;
            blr_pkg::CSR_ORIGIN_X:      origin_x_in = csr_wdata[blr_pkg::SCREEN_W-1:0];
            blr_pkg::CSR_ORIGIN_Y:      origin_y_in = csr_wdata[blr_pkg::SCREEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturated settings: a brush of zero draws one pixel, and the brush and the
   // canvas are limited to the configured maximum sizes.
   always_comb begin
      if (brush_size_ff == '0) begin
         size_sat = SW'(1);
      end else if ((SW+1)'(brush_size_ff) > (SW+1)'(MAX_BRUSH)) begin
         size_sat = SW'(MAX_BRUSH);
      end else begin
         size_sat = brush_size_ff;
      end
      width_sat  = ((DW+2)'(canvas_width_ff) > (DW+2)'(MAX_WIDTH)) ?
                   DW'(MAX_WIDTH) : canvas_width_ff;
      height_sat = ((DW+2)'(canvas_height_ff) > (DW+2)'(MAX_HEIGHT)) ?
                   DW'(MAX_HEIGHT) : canvas_height_ff;
   end

   // ---------------------------------------------------------------------
   // Line setup and Bresenham stepping, one event per accepted item.
   // ---------------------------------------------------------------------
   assign req_chan.ready = job_ready;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign new_x = $signed({1'b0, req_chan.pointer_x}) - $signed({1'b0, origin_x_ff});
   assign new_y = $signed({1'b0, req_chan.pointer_y}) - $signed({1'b0, origin_y_ff});
   assign diff_x = $signed(DLW'(new_x)) - $signed(DLW'(prev_x_ff));
   assign diff_y = $signed(DLW'(new_y)) - $signed(DLW'(prev_y_ff));
   assign abs_dx = diff_x[DLW-1] ? -diff_x : diff_x;
   assign neg_dy = diff_y[DLW-1] ? diff_y : -diff_y;

   // Both tests use the error term from before this step.
   assign e2     = {error_term_ff, 1'b0};
   assign step_x = e2 >= (EW+1)'(delta_y_neg_ff);
   assign step_y = e2 <= (EW+1)'(delta_x_ff);
   assign at_end = (cur_x_ff == end_x_ff) && (cur_y_ff == end_y_ff);

   always_comb begin
      prev_valid_in  = prev_valid_ff;
      prev_x_in      = prev_x_ff;
      prev_y_in      = prev_y_ff;
      line_active_in = line_active_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      end_x_in       = end_x_ff;
      end_y_in       = end_y_ff;
      delta_x_in     = delta_x_ff;
      delta_y_neg_in = delta_y_neg_ff;
      step_dirs_in   = step_dirs_ff;
      error_term_in  = error_term_ff;
      if (req_fire) begin
         case (req_chan.action)
            blr_pkg::ACT_PEN_DOWN: begin
               prev_x_in     = new_x;
               prev_y_in     = new_y;
               prev_valid_in = 1'b1;
            end
            blr_pkg::ACT_MOVE_TO: begin
               // Without a previous point the new point is only stored.
               if (prev_valid_ff) begin
                  cur_x_in       = prev_x_ff;
                  cur_y_in       = prev_y_ff;
                  end_x_in       = new_x;
                  end_y_in       = new_y;
                  delta_x_in     = abs_dx;
                  delta_y_neg_in = neg_dy;
                  step_dirs_in   = {diff_y[DLW-1] || (diff_y == '0),
                                    diff_x[DLW-1] || (diff_x == '0)};
                  error_term_in  = EW'(abs_dx) + EW'(neg_dy);
                  line_active_in = 1'b1;
               end
               prev_x_in     = new_x;
               prev_y_in     = new_y;
               prev_valid_in = 1'b1;
            end
            blr_pkg::ACT_STEP: begin
               if (line_active_ff) begin
                  if (at_end) begin
                     line_active_in = 1'b0;
                  end else begin
                     error_term_in = error_term_ff
                                   + (step_x ? EW'(delta_y_neg_ff) : EW'(0))
                                   + (step_y ? EW'(delta_x_ff) : EW'(0));
                     if (step_x) begin
                        cur_x_in = step_dirs_ff[0] ? cur_x_ff - CW'(1)
                                                   : cur_x_ff + CW'(1);
                     end
                     if (step_y) begin
                        cur_y_in = step_dirs_ff[1] ? cur_y_ff - CW'(1)
                                                   : cur_y_ff + CW'(1);
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff  <= blr_pkg::RST_CANVAS_WIDTH;
         canvas_height_ff <= blr_pkg::RST_CANVAS_HEIGHT;
         brush_size_ff    <= blr_pkg::RST_BRUSH_SIZE;
         pen_color_ff     <= blr_pkg::RST_PEN_COLOR;
         origin_x_ff      <= blr_pkg::RST_ORIGIN_X;
         origin_y_ff      <= blr_pkg::RST_ORIGIN_Y;
         prev_valid_ff    <= 1'b0;
         line_active_ff   <= 1'b0;
      end else begin
         canvas_width_ff  <= canvas_width_in;
         canvas_height_ff <= canvas_height_in;
         brush_size_ff    <= brush_size_in;
         pen_color_ff     <= pen_color_in;
         origin_x_ff      <= origin_x_in;
         origin_y_ff      <= origin_y_in;
         prev_valid_ff    <= prev_valid_in;
         line_active_ff   <= line_active_in;
      end
      prev_x_ff      <= prev_x_in;
      prev_y_ff      <= prev_y_in;
      cur_x_ff       <= cur_x_in;
      cur_y_ff       <= cur_y_in;
      end_x_ff       <= end_x_in;
      end_y_ff       <= end_y_in;
      delta_x_ff     <= delta_x_in;
      delta_y_neg_ff <= delta_y_neg_in;
      step_dirs_ff   <= step_dirs_in;
      error_term_ff  <= error_term_in;
   end

   // ---------------------------------------------------------------------
   // Brush stamp hand-off. The stamp uses the point before the line moves.
   // ---------------------------------------------------------------------
   assign job_valid = req_fire && (req_chan.action == blr_pkg::ACT_STEP) && line_active_ff;

   always_comb begin
      job.cur_x  = cur_x_ff;
      job.cur_y  = cur_y_ff;
      job.width  = width_sat;
      job.height = height_sat;
      job.size   = size_sat;
      job.color  = pen_color_ff;
      job.at_end = at_end;
   end

   blr_brush_emit #(
      .MAX_BRUSH (MAX_BRUSH)
   ) u_brush_emit (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_ready (job_ready),
      .rsp_chan  (rsp_chan)
   );

`ifndef SYNTH
   // A stamp is only handed over when the emitter can take it.
   assert property (@(posedge clock) disable iff (reset)
      job_valid |-> job_ready)
      else $error("brush stamp issued while emitter busy");

   // A line ends only by a step taken at its endpoint.
   assert property (@(posedge clock) disable iff (reset)
      $fell(line_active_ff) && !$past(reset)
      |-> $past(req_fire && (req_chan.action == blr_pkg::ACT_STEP)))
      else $error("line ended without a step");

   // The endpoint flag only rides on the last pixel of a stamp.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.line_done |-> rsp_chan.last_of_step)
      else $error("line_done outside the last pixel of a stamp");
`endif

endmodule

// ----- verif/blr_pixel_checker.sv -----
// ----------------------------------------------------------------------------
// Brush line rasterizer pixel checker
// Watches the event, pixel and register ports of the rasterizer, works out
// the brush pixels that every accepted event must produce, and compares each
// pixel item the block hands out against the oldest pixel still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blr_pixel_checker import blr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   blr_req_if                    req,
   blr_rsp_if                    rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    due_count,
   output int                    pixel_count,
   output int                    endpoint_count
);

   typedef struct packed {
      logic [PIX_W-1:0]   x;
      logic [PIX_W-1:0]   y;
      logic [ADDR_W-1:0]  addr;
      logic [COLOR_W-1:0] color;
      logic               we;
      logic               last;
      logic               done;
   } brush_pixel_type;

   // Register copies.
   logic [DIM_W-1:0]    cfg_w;
   logic [DIM_W-1:0]    cfg_h;
   logic [SIZE_W-1:0]   cfg_size;
   logic [COLOR_W-1:0]  cfg_color;
   logic [SCREEN_W-1:0] cfg_ox;
   logic [SCREEN_W-1:0] cfg_oy;

   // Pen and line state.
   logic                      prev_ok;
   logic                      line_on;
   logic signed [COORD_W-1:0] prev_x, prev_y, cur_x, cur_y, end_x, end_y;
   logic signed [DELTA_W-1:0] run_dx, run_dy_neg;
   logic [1:0]                dirs;
   logic signed [ERR_W-1:0]   err;

   brush_pixel_type pixels_due[$];
   brush_pixel_type seen, want;

   function automatic int mag(input int v);
      return v < 0 ? -v : v;
   endfunction

   // Applies one pointer event and queues the brush pixels it causes.
   task automatic take_event(input logic [ACTION_W-1:0] act,
                             input logic [SCREEN_W-1:0] sx,
                             input logic [SCREEN_W-1:0] sy);
      int nx, ny, ax, ay, cx, cy, size, w, h, px, py, e, e2;
      logic at_end, on_canvas, last;
      brush_pixel_type pix;
      nx = int'(sx) - int'(cfg_ox);
      ny = int'(sy) - int'(cfg_oy);
      ax = int'(prev_x);
      ay = int'(prev_y);
      case (act)
         ACT_MOVE_TO: begin
            if (prev_ok) begin
               cur_x = prev_x;
               cur_y = prev_y;
               end_x = COORD_W'(nx);
               end_y = COORD_W'(ny);
               run_dx = DELTA_W'(mag(nx - ax));
               run_dy_neg = DELTA_W'(-mag(ny - ay));
               dirs = {(ay < ny) ? 1'b0 : 1'b1, (ax < nx) ? 1'b0 : 1'b1};
               err = ERR_W'(mag(nx - ax) - mag(ny - ay));
               line_on = 1'b1;
            end
         end
         ACT_STEP: begin
            if (line_on) begin
               size = int'(cfg_size);
               if (size < 1) size = 1;
               if (size > MAX_BRUSH_DEF) size = MAX_BRUSH_DEF;
               w = (int'(cfg_w) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(cfg_w);
               h = (int'(cfg_h) > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(cfg_h);
               cx = int'(cur_x);
               cy = int'(cur_y);
               at_end = (cur_x == end_x) && (cur_y == end_y);
               for (int brow = 0; brow < size; brow++) begin
                  for (int bcol = 0; bcol < size; bcol++) begin
                     px = cx + bcol;
                     py = cy + brow;
                     on_canvas = (px >= 0) && (px < w) && (py >= 0) && (py < h);
                     last = (brow == size - 1) && (bcol == size - 1);
                     pix.x = on_canvas ? PIX_W'(px) : '0;
                     pix.y = on_canvas ? PIX_W'(py) : '0;
                     pix.addr = on_canvas ? ADDR_W'(py * w + px) : '0;
                     pix.color = cfg_color;
                     pix.we = on_canvas;
                     pix.last = last;
                     pix.done = last && at_end;
                     pixels_due.push_back(pix);
                  end
               end
               if (at_end) begin
                  line_on = 1'b0;
               end else begin
                  // Both axis decisions use the error term from before the step.
                  e = int'(err);
                  e2 = 2 * e;
                  if (e2 >= int'(run_dy_neg)) begin
                     e = e + int'(run_dy_neg);
                     cx = cx + (dirs[0] ? -1 : 1);
                  end
                  if (e2 <= int'(run_dx)) begin
                     e = e + int'(run_dx);
                     cy = cy + (dirs[1] ? -1 : 1);
                  end
                  err = ERR_W'(e);
                  cur_x = COORD_W'(cx);
                  cur_y = COORD_W'(cy);
               end
            end
         end
         default: ;
      endcase
      if (act == ACT_PEN_DOWN || act == ACT_MOVE_TO) begin
         prev_x = COORD_W'(nx);
         prev_y = COORD_W'(ny);
         prev_ok = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_w = RST_CANVAS_WIDTH;
         cfg_h = RST_CANVAS_HEIGHT;
         cfg_size = RST_BRUSH_SIZE;
         cfg_color = RST_PEN_COLOR;
         cfg_ox = RST_ORIGIN_X;
         cfg_oy = RST_ORIGIN_Y;
         prev_ok = 1'b0;
         line_on = 1'b0;
         prev_x = '0;
         prev_y = '0;
         cur_x = '0;
         cur_y = '0;
         end_x = '0;
         end_y = '0;
         run_dx = '0;
         run_dy_neg = '0;
         dirs = '0;
         err = '0;
         pixels_due.delete();
         fail_count = 0;
         pixel_count = 0;
         endpoint_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CANVAS_WIDTH:  cfg_w = csr_wdata[DIM_W-1:0];
               CSR_CANVAS_HEIGHT: cfg_h = csr_wdata[DIM_W-1:0];
               CSR_BRUSH_SIZE:    cfg_size = csr_wdata[SIZE_W-1:0];
               CSR_PEN_COLOR:     cfg_color = csr_wdata[COLOR_W-1:0];
               CSR_ORIGIN_X:      cfg_ox = csr_wdata[SCREEN_W-1:0];
               CSR_ORIGIN_Y:      cfg_oy = csr_wdata[SCREEN_W-1:0];
               default: ;
            endcase
         end
         // Pixels leaving at this edge belong to events accepted earlier, so
         // they are checked before this edge's event is applied.
         if (rsp.valid && rsp.ready) begin
            seen.x = rsp.pixel_x;
            seen.y = rsp.pixel_y;
            seen.addr = rsp.pixel_address;
            seen.color = rsp.pixel_color;
            seen.we = rsp.write_enable;
            seen.last = rsp.last_of_step;
            seen.done = rsp.line_done;
            if (pixels_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("checker: pixel item %0d arrived with none due", pixel_count);
            end else begin
               want = pixels_due.pop_front();
               if (seen !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"checker: pixel item %0d (expected/actual) x %0d/%0d",
                               " y %0d/%0d addr %0d/%0d color %h/%h we %b/%b",
                               " last %b/%b done %b/%b"},
                              pixel_count, want.x, seen.x, want.y, seen.y,
                              want.addr, seen.addr, want.color, seen.color,
                              want.we, seen.we, want.last, seen.last,
                              want.done, seen.done);
               end
            end
            pixel_count++;
            if (seen.done) endpoint_count++;
         end
         if (req.valid && req.ready)
            take_event(req.action, req.pointer_x, req.pointer_y);
      end
      due_count = pixels_due.size();
   end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Brush line rasterizer testbench
// Drives pointer events and register settings into the rasterizer, stalls
// the pixel side at random, and lets the pixel checker compare every brush
// pixel the block produces. A short directed run comes first, then phases of
// random strokes under different canvas, brush and origin settings, and a
// back-pressure run that fills the block while the pixel side holds off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import blr_pkg::*;

   // The action code that the block has no meaning for.
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   // Only meant to trip when the block has stopped making progress.
   localparam int CYCLE_LIMIT = 200000;
   // Cycles allowed after the last pixel before settings change or the run ends.
   localparam int SETTLE_CYCLES = 8;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   blr_req_if req_chan ();
   blr_rsp_if rsp_chan ();

   int fail_count;
   int due_count;
   int pixel_count;
   int endpoint_count;

   // Stimulus knobs, all written by the main stimulus process only.
   int idle_pct;
   int stall_pct;
   int hold_len;
   int hold_seq;
   int sent_count;
   int cycle_count = 0;

   // Register values as last written, used to aim strokes at the canvas.
   int cfg_w, cfg_h, cfg_size, cfg_ox, cfg_oy;

   brush_line_rasterizer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   blr_pixel_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req_chan),
      .rsp            (rsp_chan),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .due_count      (due_count),
      .pixel_count    (pixel_count),
      .endpoint_count (endpoint_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run guard: if the block hangs, end the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: timed out after %0d cycles, %0d pixels still due",
                  cycle_count, due_count);
         $display("tb: done, errors");
         $finish;
      end
   end

   // Pixel side. Ready changes only at the falling edge. A request from the
   // stimulus process (a bump of hold_seq) makes it hold ready low for
   // hold_len cycles, counted here; otherwise it stalls at stall_pct.
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_len;
         end
         if (hold_left > 0) begin
            rsp_chan.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Offers one event item and returns at the falling edge after it was
   // taken. Valid stays high on return so the next item can follow with no
   // gap; the sender idles at idle_pct before raising it.
   task automatic send_raw(input logic [ACTION_W-1:0] act,
                           input logic [SCREEN_W-1:0] sx,
                           input logic [SCREEN_W-1:0] sy);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.action = act;
      req_chan.pointer_x = sx;
      req_chan.pointer_y = sy;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   // Sends an event at a canvas-relative point; the screen point wraps the
   // same way the 12-bit pointer fields do.
   task automatic send_event(input logic [ACTION_W-1:0] act, input int rx,
                             input int ry);
      send_raw(act, SCREEN_W'(cfg_ox + rx), SCREEN_W'(cfg_oy + ry));
   endtask

   // Stops offering items and waits until every pixel due has arrived, plus
   // a few cycles for a step that had no line to draw.
   task automatic wait_idle;
      req_chan.valid = 1'b0;
      while (due_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One register write. Now and then the unused upper bits of the write
   // data carry junk, which the block must drop.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value,
                            input int width);
      logic [CSR_DATA_W-1:0] junk;
      junk = ($urandom_range(3) == 0) ? ($urandom() << width) : '0;
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = CSR_DATA_W'(value) | junk;
      @(negedge clock);
   endtask

   task automatic program_canvas(input int w, input int h, input int s,
                                 input logic [COLOR_W-1:0] color,
                                 input int ox, input int oy);
      cfg_w = w;
      cfg_h = h;
      cfg_size = s;
      cfg_ox = ox;
      cfg_oy = oy;
      write_reg(CSR_CANVAS_WIDTH, w, DIM_W);
      write_reg(CSR_CANVAS_HEIGHT, h, DIM_W);
      write_reg(CSR_BRUSH_SIZE, s, SIZE_W);
      write_reg(CSR_PEN_COLOR, int'(color), COLOR_W);
      write_reg(CSR_ORIGIN_X, ox, SCREEN_W);
      write_reg(CSR_ORIGIN_Y, oy, SCREEN_W);
      csr_we = 1'b0;
   endtask

   // A canvas-relative coordinate, often on or just past one of the edges
   // so that the brush gets clipped.
   function automatic int pick_coord(input int limit);
      case ($urandom_range(3))
         0: return int'($urandom_range(4)) - 2;
         1: return limit - 3 + int'($urandom_range(4));
         default: return int'($urandom_range(limit + 5)) - 3;
      endcase
   endfunction

   // A well-formed stroke: pen down, one or two line segments, and enough
   // steps to reach each endpoint. Some strokes are twisted: cut short (the
   // next move abandons the line), given one step too many (a step while
   // idle), or given a pen down in the middle of the line.
   task automatic draw_stroke;
      int ew, eh, span, x0, y0, x1, y1, adx, ady, n, twist, segs;
      ew = (cfg_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cfg_w;
      eh = (cfg_h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : cfg_h;
      // Big brushes give up to 25 pixels a step, so their lines stay short.
      span = (cfg_size >= 3) ? 4 : 9;
      x0 = pick_coord(ew);
      y0 = pick_coord(eh);
      send_event(ACT_PEN_DOWN, x0, y0);
      segs = ($urandom_range(3) == 0) ? 2 : 1;
      repeat (segs) begin
         x1 = x0 + int'($urandom_range(2 * span)) - span;
         y1 = y0 + int'($urandom_range(2 * span)) - span;
         send_event(ACT_MOVE_TO, x1, y1);
         adx = (x1 > x0) ? x1 - x0 : x0 - x1;
         ady = (y1 > y0) ? y1 - y0 : y0 - y1;
         n = ((adx > ady) ? adx : ady) + 1;
         twist = $urandom_range(9);
         if (twist == 0) n = $urandom_range(n - 1);
         if (twist == 1) n++;
         for (int i = 0; i < n; i++) begin
            if (twist == 2 && i == n / 2) begin
               // The running line carries on; only the next start moves.
               x1 = pick_coord(ew);
               y1 = pick_coord(eh);
               send_event(ACT_PEN_DOWN, x1, y1);
            end
            // Pointer fields are ignored on a step, so they carry noise.
            send_raw(ACT_STEP, SCREEN_W'($urandom()), SCREEN_W'($urandom()));
         end
         x0 = x1;
         y0 = y1;
      end
   endtask

   // Mostly strokes; the rest are events with random codes and points
   // anywhere on the screen, unused action code included.
   task automatic run_strokes(input int quota);
      int start;
      start = sent_count;
      while (sent_count - start < quota) begin
         if ($urandom_range(99) < 75)
            draw_stroke();
         else
            send_raw(ACTION_W'($urandom_range(3)), SCREEN_W'($urandom()),
                     SCREEN_W'($urandom()));
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_CANVAS_WIDTH;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.action = ACT_PEN_DOWN;
      req_chan.pointer_x = '0;
      req_chan.pointer_y = '0;
      idle_pct = 0;
      stall_pct = 0;
      hold_len = 0;
      hold_seq = 0;
      sent_count = 0;
      cfg_w = int'(RST_CANVAS_WIDTH);
      cfg_h = int'(RST_CANVAS_HEIGHT);
      cfg_size = int'(RST_BRUSH_SIZE);
      cfg_ox = int'(RST_ORIGIN_X);
      cfg_oy = int'(RST_ORIGIN_Y);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed events under the reset settings: a 586 x 256 canvas with a
      // brush of two, origin at screen (2, 72).
      send_raw(ACT_STEP, '0, '0);                  // step with no line
      send_event(ACT_MOVE_TO, 8, 8);                // move with no previous point
      send_raw(ACT_UNUSED, 12'hFFF, 12'hFFF);       // ignored action code
      send_event(ACT_MOVE_TO, 11, 10);              // shallow line, four points
      repeat (4) send_raw(ACT_STEP, 12'hFFF, '0);
      send_raw(ACT_STEP, '0, 12'hFFF);              // line finished, idle again
      send_raw(ACT_PEN_DOWN, '0, '0);               // left of and above canvas
      send_raw(ACT_MOVE_TO, 12'hFFF, 12'hFFF);      // far corner of the screen
      send_raw(ACT_STEP, '0, '0);                   // fully clipped stamp
      send_raw(ACT_PEN_DOWN, 12'hFFF, '0);          // pen down while drawing
      send_raw(ACT_STEP, '0, '0);                   // old line keeps going
      send_event(ACT_MOVE_TO, 585, 255);            // abandons the long line
      send_raw(ACT_STEP, '0, '0);
      send_event(ACT_PEN_DOWN, 584, 254);
      send_event(ACT_MOVE_TO, 586, 256);            // runs off the lower right
      repeat (3) send_raw(ACT_STEP, '0, '0);
      send_event(ACT_MOVE_TO, 583, 256);            // right to left, just below the canvas
      repeat (2) send_raw(ACT_STEP, '0, '0);
      wait_idle();

      // Random phases. The first four use fixed settings, among them the extremes
      // of every register; the rest are random settings, mostly small canvases. The idling
      // pattern rotates: none, sender idle, pixel side stalling, both.
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: program_canvas(0, 1024, 0, 32'h0000_0000, 0, 0);
            1: program_canvas(2047, 2047, 7, 32'hFFFF_FFFF, 4095, 4095);
            2: program_canvas(1, 1, 5, $urandom(), 0, 4095);
            3: program_canvas(1024, 1024, 1, $urandom(), 3000, 100);
            default: program_canvas(
               ($urandom_range(3) == 0) ? $urandom_range(1024, 1) : $urandom_range(48, 1),
               ($urandom_range(3) == 0) ? $urandom_range(1024, 1) : $urandom_range(48, 1),
               $urandom_range(7), $urandom(), $urandom_range(4095),
               $urandom_range(4095));
         endcase
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 45; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 45; end
            default: begin idle_pct = 11; stall_pct = 11; end
         endcase
         run_strokes((p < 3) ? 9 : 14);
         wait_idle();
      end

      // Back-pressure: the pixel side holds off for a long stretch while
      // steps of a big brush keep coming, so the block fills up and has to
      // stall its event input.
      program_canvas(1024, 1024, 5, 32'h00FF_00FF, 100, 100);
      idle_pct = 0;
      stall_pct = 0;
      send_event(ACT_PEN_DOWN, 10, 10);
      send_event(ACT_MOVE_TO, 22, 17);
      hold_len = 400;
      hold_seq++;
      repeat (13) send_raw(ACT_STEP, SCREEN_W'($urandom()), SCREEN_W'($urandom()));
      wait_idle();
      repeat (10) @(negedge clock);

      $display("tb: %0d pointer events, %0d pixel items checked, %0d lines finished",
               sent_count, pixel_count, endpoint_count);
      $display("tb: covered clipping on all edges, brush and canvas saturation, %s",
               "abandoned lines and a long pixel-side hold-off");
      if (fail_count == 0 && due_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
